[design/ebi_pkg.sv]
// ----------------------------------------------------------------------------
// Encoder and button input package
// Beat types, reset values and the quadrature step table shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package ebi_pkg;

    localparam int unsigned NUM_BUTTONS_DEF = 4;
    localparam int unsigned COUNT_WIDTH_DEF = 16;
    localparam int unsigned LEVEL_BITS      = 4;
    localparam int unsigned TIME_BITS       = 32;
    localparam int unsigned TURN_BITS       = 16;
    localparam int unsigned DEBOUNCE_BITS   = 16;

    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [3:0]               HISTORY_RESET  = 4'd3;

    typedef struct packed {
        logic                  enc_sample;
        logic                  enc_a;
        logic                  enc_b;
        logic                  btn_sample;
        logic [LEVEL_BITS-1:0] button_levels;
        logic [TIME_BITS-1:0]  now_ms;
        logic                  collect;
    } tick_t;

    typedef struct packed {
        logic [TURN_BITS-1:0]  right_turns;
        logic [TURN_BITS-1:0]  left_turns;
        logic [LEVEL_BITS-1:0] pressed_buttons;
        logic                  activity;
    } report_t;

    function automatic logic signed [1:0] enc_step(input logic [3:0] history);
        logic signed [1:0] step;
        unique case (history)
            4'd1, 4'd7, 4'd8, 4'd14:  step = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
            default:                  step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

[design/encoder_and_button_input_core.sv]
// ----------------------------------------------------------------------------
// Encoder and button input core
// Quadrature decoding with step accumulation and saturating turn counts, and
// debouncing of active-low buttons against wrapping millisecond time.
// ----------------------------------------------------------------------------
// Path: an accepted tick beat waits in the tick register until the report
// register is free, then its report is loaded there and offered as a beat.
// Throughput: one tick beat per cycle while the report output is not stalled,
// with the state update between the tick register and the report register.
// Reset: asynchronous, active low; all state but the tick and report data
// returns to its released and cleared values; debounce time returns to 50 ms.
`default_nettype none

module encoder_and_button_input_core #(
    parameter int unsigned NUM_BUTTONS = ebi_pkg::NUM_BUTTONS_DEF,
    parameter int unsigned COUNT_WIDTH = ebi_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                tick_valid,
    output logic                                     tick_stall,
    input  wire ebi_pkg::tick_t                      tick,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output ebi_pkg::report_t                         result,
    input  wire logic                                cfg_we,
    input  wire logic [ebi_pkg::DEBOUNCE_BITS-1:0]   cfg_data
);

    import ebi_pkg::*;

    logic                       tick_valid_reg;
    tick_t                      tick_reg;
    logic                       result_valid_reg;
    report_t                    result_reg;
    report_t                    result_next;

    logic [DEBOUNCE_BITS-1:0]   debounce_reg;
    logic [3:0]                 history_reg;
    logic [3:0]                 history_next;
    logic signed [3:0]          acc_reg;
    logic signed [3:0]          acc_next;
    logic [COUNT_WIDTH-1:0]     right_reg;
    logic [COUNT_WIDTH-1:0]     right_next;
    logic [COUNT_WIDTH-1:0]     left_reg;
    logic [COUNT_WIDTH-1:0]     left_next;
    logic [NUM_BUTTONS-1:0]     stable_reg;
    logic [NUM_BUTTONS-1:0]     stable_next;
    logic [NUM_BUTTONS-1:0]     prev_reg;
    logic [NUM_BUTTONS-1:0]     prev_next;
    logic [TIME_BITS-1:0]       change_reg [NUM_BUTTONS];
    logic [TIME_BITS-1:0]       change_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]     press_reg;
    logic [NUM_BUTTONS-1:0]     press_next;
    logic                       activity_reg;
    logic                       activity_next;

    logic                       result_free;
    logic                       advance;

    assign result_free  = !result_valid_reg || !result_stall;
    assign advance      = tick_valid_reg && result_free;
    assign tick_stall   = tick_valid_reg && !result_free;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        logic signed [1:0]              step;
        logic signed [3:0]              acc_sum;
        logic [COUNT_WIDTH:0]           right_sum;
        logic [COUNT_WIDTH:0]           left_sum;
        logic [NUM_BUTTONS+LEVEL_BITS-1:0] level_pad;
        logic [NUM_BUTTONS+LEVEL_BITS-1:0] press_pad;
        logic [TIME_BITS-1:0]           elapsed;
        logic [TIME_BITS-1:0]           right_wide;
        logic [TIME_BITS-1:0]           left_wide;
        logic                           raw;

        history_next  = history_reg;
        acc_next      = acc_reg;
        right_next    = right_reg;
        left_next     = left_reg;
        stable_next   = stable_reg;
        prev_next     = prev_reg;
        press_next    = press_reg;
        activity_next = activity_reg;
        elapsed       = '0;
        raw           = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            change_next[i] = change_reg[i];
        end

        right_sum = {1'b0, right_reg} + (COUNT_WIDTH+1)'(2);
        left_sum  = {1'b0, left_reg} + (COUNT_WIDTH+1)'(2);

        history_next = {history_reg[1:0], tick_reg.enc_a, tick_reg.enc_b};
        step         = enc_step(history_next);
        acc_sum      = acc_reg + {{2{step[1]}}, step};

        if (tick_reg.enc_sample)
        begin
            acc_next = acc_sum;
            if (acc_sum > 4'sd3)
            begin
                right_next    = right_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                       : right_sum[COUNT_WIDTH-1:0];
                acc_next      = 4'sd0;
                activity_next = 1'b1;
            end
            else if (acc_sum < -4'sd3)
            begin
                left_next     = left_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}}
                                                      : left_sum[COUNT_WIDTH-1:0];
                acc_next      = 4'sd0;
                activity_next = 1'b1;
            end
        end
        else
        begin
            history_next = history_reg;
        end

        level_pad = {{NUM_BUTTONS{1'b0}}, tick_reg.button_levels};
        if (tick_reg.btn_sample)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                raw = level_pad[i];
                if (raw != prev_reg[i])
                begin
                    change_next[i] = tick_reg.now_ms;
                end
                elapsed = tick_reg.now_ms - change_next[i];
                if (elapsed > TIME_BITS'(debounce_reg) && raw != stable_reg[i])
                begin
                    stable_next[i] = raw;
                    if (!raw)
                    begin
                        press_next[i] = 1'b1;
                        activity_next = 1'b1;
                    end
                end
                prev_next[i] = raw;
            end
        end

        press_pad  = {{LEVEL_BITS{1'b0}}, press_next};
        right_wide = TIME_BITS'(right_next);
        left_wide  = TIME_BITS'(left_next);

        result_next = '0;
        if (tick_reg.collect)
        begin
            result_next.right_turns     = right_wide[TURN_BITS-1:0];
            result_next.left_turns      = left_wide[TURN_BITS-1:0];
            result_next.pressed_buttons = press_pad[LEVEL_BITS-1:0];
            result_next.activity        = activity_next;
            right_next    = '0;
            left_next     = '0;
            press_next    = '0;
            activity_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            debounce_reg     <= DEBOUNCE_RESET;
            history_reg      <= HISTORY_RESET;
            acc_reg          <= 4'sd0;
            right_reg        <= '0;
            left_reg         <= '0;
            stable_reg       <= '1;
            prev_reg         <= '1;
            press_reg        <= '0;
            activity_reg     <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                change_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                debounce_reg <= cfg_data;
            end

            if (tick_valid && !tick_stall)
            begin
                tick_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                tick_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                history_reg  <= history_next;
                acc_reg      <= acc_next;
                right_reg    <= right_next;
                left_reg     <= left_next;
                stable_reg   <= stable_next;
                prev_reg     <= prev_next;
                press_reg    <= press_next;
                activity_reg <= activity_next;
                for (int i = 0; i < NUM_BUTTONS; i++)
                begin
                    change_reg[i] <= change_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && !tick_stall)
        begin
            tick_reg <= tick;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

[test/encoder_and_button_input_core_tb.sv]
// ----------------------------------------------------------------------------
// Encoder and button input core testbench
// Drives tick beats through the core under random idling and back-pressure,
// predicts every report with a scoreboard model of the encoder decode and the
// button debounce, and compares each report field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_and_button_input_core_tb;

    import ebi_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          BURST_SAMPLES  = 16;
    localparam int          STEP_LUT [16]  = '{0, -1, 1, 0, 1, 0, 0, -1,
                                               -1, 0, 0, 1, 0, 1, -1, 0};
    localparam logic [1:0]  GRAY_PINS [4]  = '{2'b11, 2'b01, 2'b00, 2'b10};

    class turn_press_board;
        report_t                pending[$];
        logic [DEBOUNCE_BITS-1:0] debounce;
        logic [3:0]             history;
        int                     acc;
        logic [TURN_BITS-1:0]   right_cnt;
        logic [TURN_BITS-1:0]   left_cnt;
        logic [LEVEL_BITS-1:0]  stable;
        logic [LEVEL_BITS-1:0]  last_raw;
        logic [LEVEL_BITS-1:0]  flags;
        logic [TIME_BITS-1:0]   changed_at [LEVEL_BITS];
        logic                   active;
        int                     mismatches;

        function void clear();
            int i;
            pending.delete();
            debounce   = DEBOUNCE_RESET;
            history    = HISTORY_RESET;
            acc        = 0;
            right_cnt  = '0;
            left_cnt   = '0;
            stable     = '1;
            last_raw   = '1;
            flags      = '0;
            active     = 1'b0;
            mismatches = 0;
            for (i = 0; i < LEVEL_BITS; i++)
                changed_at[i] = '0;
        endfunction

        function void set_debounce(input logic [DEBOUNCE_BITS-1:0] value);
            debounce = value;
        endfunction

        function logic [TURN_BITS-1:0] bump(input logic [TURN_BITS-1:0] count);
            return (count > {TURN_BITS{1'b1}} - TURN_BITS'(2)) ? {TURN_BITS{1'b1}}
                                                                : count + TURN_BITS'(2);
        endfunction

        function void note_tick(input tick_t t);
            report_t r;
            int      i;
            logic    raw;
            if (t.enc_sample)
            begin
                history = {history[1:0], t.enc_a, t.enc_b};
                acc     = acc + STEP_LUT[history];
                if (acc > 3)
                begin
                    right_cnt = bump(right_cnt);
                    acc       = 0;
                    active    = 1'b1;
                end
                else if (acc < -3)
                begin
                    left_cnt = bump(left_cnt);
                    acc      = 0;
                    active   = 1'b1;
                end
            end
            if (t.btn_sample)
            begin
                for (i = 0; i < LEVEL_BITS; i++)
                begin
                    raw = t.button_levels[i];
                    if (raw != last_raw[i])
                        changed_at[i] = t.now_ms;
                    if ((t.now_ms - changed_at[i]) > {16'd0, debounce} && raw != stable[i])
                    begin
                        stable[i] = raw;
                        if (!raw)
                        begin
                            flags[i] = 1'b1;
                            active   = 1'b1;
                        end
                    end
                    last_raw[i] = raw;
                end
            end
            r = '0;
            if (t.collect)
            begin
                r.right_turns     = right_cnt;
                r.left_turns      = left_cnt;
                r.pressed_buttons = flags;
                r.activity        = active;
                right_cnt         = '0;
                left_cnt          = '0;
                flags             = '0;
                active            = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_report(input report_t got);
            report_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("report beat with no tick pending: R=%0d L=%0d P=%b A=%b",
                             got.right_turns, got.left_turns, got.pressed_buttons,
                             got.activity);
                return;
            end
            want = pending.pop_front();
            if (got.right_turns !== want.right_turns || got.left_turns !== want.left_turns ||
                got.pressed_buttons !== want.pressed_buttons ||
                got.activity !== want.activity)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp R=%0d L=%0d P=%b A=%b, got R=%0d L=%0d P=%b A=%b",
                             want.right_turns, want.left_turns, want.pressed_buttons,
                             want.activity, got.right_turns, got.left_turns,
                             got.pressed_buttons, got.activity);
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     tick_valid;
    logic                     tick_stall;
    tick_t                    tick_bus;
    logic                     result_valid;
    logic                     result_stall;
    report_t                  result;
    logic                     cfg_we;
    logic [DEBOUNCE_BITS-1:0] cfg_data;

    turn_press_board          board;
    bit                       quiet;
    bit                       start_hold;
    int                       idle_cycles = 0;
    logic [1:0]               enc_phase;
    logic [1:0]               enc_dir;
    logic [LEVEL_BITS-1:0]    btn_target;
    logic [TIME_BITS-1:0]     ms_now;
    logic [DEBOUNCE_BITS-1:0] mid_debounce;

    encoder_and_button_input_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_valid && !tick_stall)
                board.note_tick(tick_bus);
            if (result_valid && !result_stall)
                board.check_report(result);
            if ((tick_valid && !tick_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (start_hold)
            begin
                start_hold = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                result_stall <= (!quiet && $urandom_range(99) < 7);
        end
    end

    function automatic tick_t compose_tick(input logic es, input logic a, input logic b,
                                           input logic bs, input logic [3:0] levels,
                                           input logic [31:0] now, input logic col);
        tick_t t;
        t.enc_sample    = es;
        t.enc_a         = a;
        t.enc_b         = b;
        t.btn_sample    = bs;
        t.button_levels = levels;
        t.now_ms        = now;
        t.collect       = col;
        return t;
    endfunction

    function automatic tick_t make_tick(input int unsigned step_max);
        tick_t       t;
        int          i;
        int unsigned pick;
        if ($urandom_range(99) < 10)
            return compose_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1)), 1'($urandom_range(1)),
                                4'($urandom_range(15)), $urandom,
                                $urandom_range(9) == 0);
        t = '0;
        if ($urandom_range(99) < 70)
        begin
            if ($urandom_range(99) < 3)
                enc_dir = -enc_dir;
            pick = $urandom_range(99);
            if (pick < 80)
                enc_phase = enc_phase + enc_dir;
            else if (pick < 88)
                enc_phase = enc_phase;
            else if (pick < 96)
                enc_phase = enc_phase - enc_dir;
            else
                enc_phase = enc_phase + 2'd2;
            t.enc_sample         = 1'b1;
            {t.enc_a, t.enc_b}   = GRAY_PINS[enc_phase];
        end
        else
        begin
            t.enc_a = 1'($urandom_range(1));
            t.enc_b = 1'($urandom_range(1));
        end
        if ($urandom_range(99) < 60)
        begin
            ms_now       = ms_now + $urandom_range(step_max);
            t.btn_sample = 1'b1;
            t.now_ms     = ms_now;
            for (i = 0; i < LEVEL_BITS; i++)
            begin
                if ($urandom_range(99) < 4)
                    btn_target[i] = ~btn_target[i];
                t.button_levels[i] = ($urandom_range(99) < 12) ? ~btn_target[i]
                                                                : btn_target[i];
            end
        end
        else
        begin
            t.button_levels = 4'($urandom_range(15));
            t.now_ms        = $urandom;
        end
        t.collect = ($urandom_range(99) < 8);
        return t;
    endfunction

    task automatic push_tick(input tick_t t);
        int gap;
        if (!quiet && $urandom_range(99) < 7)
        begin
            gap = $urandom_range(3, 1);
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_bus   <= t;
        tick_valid <= 1'b1;
        @(posedge clk);
        while (tick_stall) @(posedge clk);
    endtask

    task automatic run_random(input int count, input int unsigned step_max);
        int k;
        for (k = 0; k < count; k++)
            push_tick(make_tick(step_max));
    endtask

    task automatic spin_burst(input bit to_right);
        int k;
        for (k = 0; k < BURST_SAMPLES; k++)
        begin
            enc_phase = to_right ? enc_phase + 2'd1 : enc_phase - 2'd1;
            push_tick(compose_tick(1'b1, GRAY_PINS[enc_phase][1], GRAY_PINS[enc_phase][0],
                                   1'b0, 4'hF, 32'd0, k == BURST_SAMPLES - 1));
        end
    endtask

    task automatic write_debounce(input logic [DEBOUNCE_BITS-1:0] value);
        tick_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        board.set_debounce(value);
    endtask

    initial
    begin
        board = new;
        board.clear();
        quiet       = 1'b0;
        start_hold  = 1'b0;
        enc_phase   = 2'd0;
        enc_dir     = 2'd1;
        btn_target  = '1;
        ms_now      = 32'd1000;
        rst_n      <= 1'b0;
        tick_valid <= 1'b0;
        tick_bus   <= '0;
        cfg_we     <= 1'b0;
        cfg_data   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_tick(compose_tick(0, 0, 0, 0, 4'hF, 32'd0, 0));
        push_tick(compose_tick(0, 1, 1, 0, 4'h0, 32'hFFFF_FFFF, 1));
        push_tick(compose_tick(1, 0, 1, 0, 4'hF, 32'd0, 0));
        push_tick(compose_tick(1, 0, 0, 0, 4'hF, 32'd0, 0));
        push_tick(compose_tick(1, 1, 0, 0, 4'hF, 32'd0, 0));
        push_tick(compose_tick(1, 1, 1, 0, 4'hF, 32'd0, 1));
        push_tick(compose_tick(1, 1, 0, 0, 4'hF, 32'd0, 0));
        push_tick(compose_tick(1, 0, 0, 0, 4'hF, 32'd0, 0));
        push_tick(compose_tick(1, 0, 1, 0, 4'hF, 32'd0, 0));
        push_tick(compose_tick(1, 1, 1, 0, 4'hF, 32'd0, 1));
        push_tick(compose_tick(0, 0, 0, 1, 4'h0, 32'd10, 0));
        push_tick(compose_tick(0, 0, 0, 1, 4'h0, 32'd61, 1));
        push_tick(compose_tick(0, 0, 0, 1, 4'hF, 32'd100, 0));
        push_tick(compose_tick(0, 0, 0, 1, 4'hF, 32'd151, 1));
        push_tick(compose_tick(0, 0, 0, 1, 4'b0101, 32'hFFFF_FFF0, 0));
        push_tick(compose_tick(0, 0, 0, 1, 4'b0101, 32'h0000_0030, 1));
        push_tick(compose_tick(1, 1, 1, 1, 4'hF, 32'hFFFF_FFFF, 1));
        push_tick(compose_tick(0, 0, 0, 1, 4'h0, 32'd200, 0));
        push_tick(compose_tick(0, 0, 0, 1, 4'hF, 32'd260, 0));
        push_tick(compose_tick(0, 0, 0, 1, 4'h0, 32'd270, 0));
        push_tick(compose_tick(0, 0, 0, 1, 4'h0, 32'd300, 1));
        push_tick(compose_tick(1, 0, 0, 0, 4'hF, 32'd0, 1));
        enc_phase = 2'd2;

        write_debounce(16'd0);
        run_random(200, 3);

        write_debounce(16'hFFFF);
        ms_now = 32'hFFFF_0000;
        run_random(150, 30000);

        mid_debounce = 16'($urandom_range(200, 1));
        write_debounce(mid_debounce);
        quiet      = 1'b1;
        start_hold = 1'b1;
        run_random(200, mid_debounce / 2 + 1);
        quiet = 1'b0;
        run_random(150, mid_debounce / 2 + 1);

        spin_burst(1'b1);
        spin_burst(1'b0);

        write_debounce(16'd5);
        ms_now = 32'hFFFF_FF00;
        run_random(200, 4);

        tick_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
